// ----- src/grant_table_entry_allocator_assert.svh -----
// Assertion macros for the grant table entry allocator.
`ifndef GRANT_TABLE_ENTRY_ALLOCATOR_ASSERT_SVH
`define GRANT_TABLE_ENTRY_ALLOCATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define GTEA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define GTEA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- src/gtea_pkg.sv -----
// ----------------------------------------------------------------------------
// gtea_pkg
// Types, opcodes and flag constants shared by the grant table allocator.
// ----------------------------------------------------------------------------
package gtea_pkg;
	localparam int unsigned ENTRIES_DEF = 2048;

	localparam logic [3:0] OP_GRANT      = 4'd0;
	localparam logic [3:0] OP_GRANT_REF  = 4'd1;
	localparam logic [3:0] OP_XFER       = 4'd2;
	localparam logic [3:0] OP_XFER_REF   = 4'd3;
	localparam logic [3:0] OP_QUERY      = 4'd4;
	localparam logic [3:0] OP_END        = 4'd5;
	localparam logic [3:0] OP_END_XFER   = 4'd6;
	localparam logic [3:0] OP_RESERVE    = 4'd7;
	localparam logic [3:0] OP_CLAIM      = 4'd8;
	localparam logic [3:0] OP_RELEASE    = 4'd9;
	localparam logic [3:0] OP_FREE_BATCH = 4'd10;
	localparam logic [3:0] OP_REMOTE     = 4'd11;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_INUSE   = 2'd2;
	localparam logic [1:0] ST_PENDING = 2'd3;

	localparam logic [15:0] F_PERMIT = 16'd1;
	localparam logic [15:0] F_XFER   = 16'd2;
	localparam logic [15:0] F_RDONLY = 16'd4;
	localparam logic [15:0] F_BUSY   = 16'd24;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [10:0] entry_ref;
		logic [15:0] domain_id;
		logic [31:0] frame_number;
		logic        read_only;
		logic [11:0] batch_count;
		logic [11:0] private_head_in;
		logic [11:0] chain_end;
		logic [15:0] remote_flags;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] result_ref;
		logic [11:0] chain_head;
		logic [11:0] chain_terminal;
		logic [31:0] frame_out;
		logic [4:0]  busy_bits;
	} rsp_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;    // capture request
		logic rd;      // issue memory read at current pointer
		logic exec;    // apply the single-entry operation
		logic walk;    // one step of a batch walk
		logic restore; // reserve failed: restore free head
		logic init;    // one step of the link initialization sweep
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic batch;     // request is a batch opcode
		logic walk_done; // batch walk ends this step
		logic walk_fail; // reserve ran out
		logic init_done;
	} sts_t;
endpackage

// ----- src/gtea_if.sv -----
// ----------------------------------------------------------------------------
// gtea_req_if / gtea_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface gtea_req_if;
	logic           valid;
	logic           ready;
	gtea_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gtea_rsp_if;
	logic           valid;
	logic           ready;
	gtea_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/gtea_ctrl.sv -----
// ----------------------------------------------------------------------------
// gtea_ctrl
// Sequencer: link sweep after reset, read then execute, batch walks.
// ----------------------------------------------------------------------------
module gtea_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  gtea_pkg::sts_t sts,
	output gtea_pkg::cmd_t cmd
);
	typedef enum logic [2:0] {S_INIT, S_IDLE, S_READ, S_EXEC, S_WALK, S_OUT} state_t;
	state_t state_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.init    = (state_q == S_INIT);
		cmd.load    = (state_q == S_IDLE) && in_valid;
		cmd.rd      = (state_q == S_READ);
		cmd.exec    = (state_q == S_EXEC);
		cmd.walk    = (state_q == S_WALK);
		cmd.restore = (state_q == S_WALK) && sts.walk_fail;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			case (state_q)
				S_INIT: if (sts.init_done) state_q <= S_IDLE;
				S_IDLE: if (in_valid) state_q <= S_READ;
				S_READ: state_q <= sts.batch ? S_WALK : S_EXEC;
				S_EXEC: state_q <= S_OUT;
				S_WALK: if (sts.walk_done || sts.walk_fail) state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- src/gtea_dp.sv -----
// ----------------------------------------------------------------------------
// gtea_dp
// Entry memories, free list head, batch walk counter and result register.
// ----------------------------------------------------------------------------
module gtea_dp #(
	parameter int unsigned ENTRIES = gtea_pkg::ENTRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  gtea_pkg::req_t req,
	input  gtea_pkg::cmd_t cmd,
	output gtea_pkg::sts_t sts,
	output gtea_pkg::rsp_t rsp
);
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [11:0] END_MARK = 12'(ENTRIES);

	logic [11:0] link_mem [ENTRIES];
	logic [15:0] flag_mem [ENTRIES];
	logic [31:0] frm_mem  [ENTRIES];

	gtea_pkg::req_t req_q;
	logic [11:0] free_head_q, saved_head_q, cnt_q, ptr_q;
	logic [11:0] link_rd_q;
	logic [15:0] flag_rd_q;
	logic [31:0] frm_rd_q;
	logic [AW-1:0] init_q;
	logic        init_done_q;

	logic [11:0] ref12;
	logic        inr;
	logic [11:0] rd_addr;
	logic        rd_inr;
	assign ref12   = {1'b0, req_q.entry_ref};
	assign inr     = ref12 < END_MARK;
	assign rd_inr  = rd_addr < END_MARK;

	// Address used for the pending read.
	always_comb begin
		case (req_q.opcode)
			gtea_pkg::OP_GRANT, gtea_pkg::OP_XFER,
			gtea_pkg::OP_RESERVE:                  rd_addr = free_head_q;
			gtea_pkg::OP_CLAIM:                    rd_addr = req_q.private_head_in;
			default:                               rd_addr = ref12;
		endcase
	end

	logic batch_op;
	assign batch_op = (req_q.opcode == gtea_pkg::OP_RESERVE) ||
		(req_q.opcode == gtea_pkg::OP_FREE_BATCH);

	// Walk step: reserve follows free_head, free_batch follows ptr_q.
	logic w_rsv, w_stop, w_fail;
	assign w_rsv  = (req_q.opcode == gtea_pkg::OP_RESERVE);
	assign w_fail = w_rsv && (cnt_q != 12'd0) && !(free_head_q < END_MARK);
	assign w_stop = (cnt_q == 12'd0) || (!w_rsv && !(ptr_q < END_MARK));

	assign sts.batch     = batch_op;
	assign sts.walk_done = w_stop && !w_fail;
	assign sts.walk_fail = w_fail;
	assign sts.init_done = init_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			init_q      <= '0;
			init_done_q <= 1'b0;
		end else begin
			if (cmd.init) begin
				init_q <= init_q + AW'(1);
				if (init_q == AW'(ENTRIES - 1)) init_done_q <= 1'b1;
			end
			if (cmd.exec) begin
				case (req_q.opcode)
					gtea_pkg::OP_GRANT, gtea_pkg::OP_XFER:
						if (free_head_q < END_MARK) free_head_q <= link_rd_q;
					gtea_pkg::OP_END:
						if (inr) free_head_q <= ref12;
					gtea_pkg::OP_END_XFER:
						if (inr) begin
							if (flag_rd_q == gtea_pkg::F_XFER) begin
								free_head_q <= ref12;
							end else if (frm_rd_q != 32'd0) begin
								free_head_q <= ref12;
							end
						end
					default: ;
				endcase
			end
			if (cmd.walk && !w_stop) begin
				if (w_rsv) begin
					if (!w_fail) free_head_q <= link_rd_q;
				end else begin
					free_head_q <= ptr_q;
				end
			end
			if (cmd.restore) free_head_q <= saved_head_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			link_mem[init_q] <= 12'(32'(init_q) + 1);
			flag_mem[init_q] <= 16'd0;
		end
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.rd) begin
			link_rd_q    <= link_mem[rd_addr[AW-1:0]];
			flag_rd_q    <= flag_mem[ref12[AW-1:0]];
			frm_rd_q     <= frm_mem[ref12[AW-1:0]];
			saved_head_q <= free_head_q;
			cnt_q        <= req_q.batch_count;
			ptr_q        <= ref12;
			rsp          <= '0;
		end
		if (cmd.walk && !w_stop) begin
			cnt_q <= cnt_q - 12'd1;
			// link_rd_q always holds the successor of the node taken in this step.
			if (w_rsv) begin
				link_rd_q <= link_mem[link_rd_q[AW-1:0]];
			end else begin
				link_mem[ptr_q[AW-1:0]] <= free_head_q;
				ptr_q <= link_rd_q;
				// A chain that points back at the node freed now sees its new link.
				link_rd_q <= (link_rd_q == ptr_q) ? free_head_q
					: link_mem[link_rd_q[AW-1:0]];
			end
		end
		if (cmd.walk && w_rsv && !w_fail && w_stop) begin
			rsp.chain_head     <= saved_head_q;
			rsp.chain_terminal <= free_head_q;
		end
		if (cmd.restore) rsp.status <= gtea_pkg::ST_NOSPACE;
		if (cmd.exec) begin
			case (req_q.opcode)
				gtea_pkg::OP_GRANT, gtea_pkg::OP_XFER:
					if (free_head_q < END_MARK) begin
						frm_mem[free_head_q[AW-1:0]] <= req_q.frame_number;
						flag_mem[free_head_q[AW-1:0]] <= (req_q.opcode == gtea_pkg::OP_GRANT)
							? (gtea_pkg::F_PERMIT | (req_q.read_only ? gtea_pkg::F_RDONLY : 16'd0))
							: gtea_pkg::F_XFER;
						rsp.result_ref <= free_head_q;
					end else begin
						rsp.status <= gtea_pkg::ST_NOSPACE;
					end
				gtea_pkg::OP_GRANT_REF, gtea_pkg::OP_XFER_REF:
					if (inr) begin
						frm_mem[ref12[AW-1:0]] <= req_q.frame_number;
						flag_mem[ref12[AW-1:0]] <= (req_q.opcode == gtea_pkg::OP_GRANT_REF)
							? (gtea_pkg::F_PERMIT | (req_q.read_only ? gtea_pkg::F_RDONLY : 16'd0))
							: gtea_pkg::F_XFER;
					end
				gtea_pkg::OP_QUERY:
					if (inr) rsp.busy_bits <= 5'(flag_rd_q & gtea_pkg::F_BUSY);
				gtea_pkg::OP_END:
					if (inr) begin
						if ((flag_rd_q & gtea_pkg::F_BUSY) != 16'd0)
							rsp.status <= gtea_pkg::ST_INUSE;
						flag_mem[ref12[AW-1:0]] <= 16'd0;
						link_mem[ref12[AW-1:0]] <= free_head_q;
					end
				gtea_pkg::OP_END_XFER:
					if (inr) begin
						if (flag_rd_q == gtea_pkg::F_XFER) begin
							flag_mem[ref12[AW-1:0]] <= 16'd0;
							link_mem[ref12[AW-1:0]] <= free_head_q;
						end else if (frm_rd_q == 32'd0) begin
							rsp.status <= gtea_pkg::ST_PENDING;
						end else begin
							rsp.frame_out <= frm_rd_q;
							link_mem[ref12[AW-1:0]] <= free_head_q;
						end
					end
				gtea_pkg::OP_CLAIM:
					if (req_q.private_head_in == req_q.chain_end || !rd_inr) begin
						rsp.status <= gtea_pkg::ST_NOSPACE;
					end else begin
						rsp.result_ref <= req_q.private_head_in;
						rsp.chain_head <= link_rd_q;
					end
				gtea_pkg::OP_RELEASE:
					if (inr) begin
						link_mem[ref12[AW-1:0]] <= req_q.private_head_in;
						rsp.chain_head <= ref12;
					end else begin
						rsp.chain_head <= req_q.private_head_in;
					end
				gtea_pkg::OP_REMOTE:
					if (inr) begin
						flag_mem[ref12[AW-1:0]] <= req_q.remote_flags;
						frm_mem[ref12[AW-1:0]] <= req_q.frame_number;
					end
				default: ;
			endcase
		end
	end
endmodule

// ----- src/grant_table_entry_allocator.sv -----
// ----------------------------------------------------------------------------
// grant_table_entry_allocator
// Grant entry table with an array-linked free list.
// ----------------------------------------------------------------------------
// One request is handled at a time. A single-entry opcode shows its result
// after a memory read and then a read-modify-write; reserve and free_batch
// show it after the read and a walk of one entry per step, set by the one
// link-memory read per cycle. The input is ready again the cycle after the
// result is taken. After reset a sweep over every entry writes the free-list
// links and clears the flags before the first request is accepted.
module grant_table_entry_allocator #(
	parameter int unsigned ENTRIES = gtea_pkg::ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	gtea_req_if.sink   req,
	gtea_rsp_if.source rsp
);
	gtea_pkg::cmd_t cmd;
	gtea_pkg::sts_t sts;

	gtea_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.sts(sts), .cmd(cmd)
	);

	gtea_dp #(.ENTRIES(ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.req(req.data), .cmd(cmd), .sts(sts), .rsp(rsp.data)
	);
endmodule

// ----- src/gtea_checker.sv -----
// ----------------------------------------------------------------------------
// gtea_checker
// Port-level checks of the allocator handshake and result sequencing.
// ----------------------------------------------------------------------------
`include "grant_table_entry_allocator_assert.svh"
module gtea_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);
	// A request is never taken while a result is still shown.
	`GTEA_ASSERT_IMP(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	// After acceptance no result appears in the next cycle.
	`GTEA_ASSERT_NEXT(a_latency, clk, arst_n, in_valid && in_ready, !out_valid && !in_ready)
	// A result that is taken frees the input side in the next cycle.
	`GTEA_ASSERT_NEXT(a_drain, clk, arst_n, out_valid && out_ready, in_ready)
endmodule

bind grant_table_entry_allocator gtea_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(req.valid), .in_ready(req.ready),
	.out_valid(rsp.valid), .out_ready(rsp.ready)
);

// ----- tb/gtea_scoreboard.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtea_scoreboard
// Watches the request and result channels of the grant table allocator, keeps
// its own copy of the entry table and free list, predicts one result for
// every accepted request and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module gtea_scoreboard #(
	parameter int unsigned ENTRIES = gtea_pkg::ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	gtea_req_if        req,
	gtea_rsp_if        rsp,
	output int         fail_count,
	output int         outstanding
);
	logic [11:0] link_mem [ENTRIES];
	logic [15:0] flag_mem [ENTRIES];
	logic [31:0] frame_mem [ENTRIES];
	logic [11:0] free_head;
	gtea_pkg::rsp_t expected_q [$];

	function automatic void return_entry(logic [11:0] idx);
		link_mem[idx] = free_head;
		free_head = idx;
	endfunction

	function automatic void fill_entry(logic [10:0] idx, gtea_pkg::req_t r,
		logic [15:0] flags);
		frame_mem[idx] = r.frame_number;
		flag_mem[idx] = flags;
	endfunction

	function automatic logic [15:0] grant_flags(gtea_pkg::req_t r);
		return gtea_pkg::F_PERMIT | (r.read_only ? gtea_pkg::F_RDONLY : 16'd0);
	endfunction

	// Applies one request to the table copy and returns the result it causes.
	function automatic gtea_pkg::rsp_t apply_request(gtea_pkg::req_t r);
		gtea_pkg::rsp_t o;
		logic        in_range;
		logic [11:0] idx;
		logic [11:0] saved_head;
		logic [11:0] walk;
		logic        ok;
		o = '0;
		in_range = r.entry_ref < ENTRIES;
		case (r.opcode)
			gtea_pkg::OP_GRANT, gtea_pkg::OP_XFER: begin
				if (free_head >= ENTRIES) begin
					o.status = gtea_pkg::ST_NOSPACE;
				end else begin
					idx = free_head;
					free_head = link_mem[idx];
					fill_entry(idx[10:0], r,
						r.opcode == gtea_pkg::OP_GRANT ? grant_flags(r) : gtea_pkg::F_XFER);
					o.result_ref = idx;
				end
			end
			gtea_pkg::OP_GRANT_REF, gtea_pkg::OP_XFER_REF: begin
				if (in_range)
					fill_entry(r.entry_ref, r,
						r.opcode == gtea_pkg::OP_GRANT_REF ? grant_flags(r) : gtea_pkg::F_XFER);
			end
			gtea_pkg::OP_QUERY: begin
				if (in_range)
					o.busy_bits = 5'(flag_mem[r.entry_ref] & gtea_pkg::F_BUSY);
			end
			gtea_pkg::OP_END: begin
				if (in_range) begin
					if ((flag_mem[r.entry_ref] & gtea_pkg::F_BUSY) != 0)
						o.status = gtea_pkg::ST_INUSE;
					flag_mem[r.entry_ref] = '0;
					return_entry({1'b0, r.entry_ref});
				end
			end
			gtea_pkg::OP_END_XFER: begin
				if (in_range) begin
					if (flag_mem[r.entry_ref] == gtea_pkg::F_XFER) begin
						flag_mem[r.entry_ref] = '0;
						return_entry({1'b0, r.entry_ref});
					end else if (frame_mem[r.entry_ref] == 0) begin
						// Transfer not yet committed by the remote side.
						o.status = gtea_pkg::ST_PENDING;
					end else begin
						o.frame_out = frame_mem[r.entry_ref];
						return_entry({1'b0, r.entry_ref});
					end
				end
			end
			gtea_pkg::OP_RESERVE: begin
				saved_head = free_head;
				ok = 1'b1;
				for (int i = 0; i < r.batch_count; i++) begin
					if (free_head >= ENTRIES) begin
						ok = 1'b0;
						break;
					end
					free_head = link_mem[free_head];
				end
				if (ok) begin
					o.chain_head = saved_head;
					o.chain_terminal = free_head;
				end else begin
					free_head = saved_head;
					o.status = gtea_pkg::ST_NOSPACE;
				end
			end
			gtea_pkg::OP_CLAIM: begin
				if (r.private_head_in == r.chain_end || r.private_head_in >= ENTRIES) begin
					o.status = gtea_pkg::ST_NOSPACE;
				end else begin
					o.result_ref = r.private_head_in;
					o.chain_head = link_mem[r.private_head_in];
				end
			end
			gtea_pkg::OP_RELEASE: begin
				if (in_range) begin
					link_mem[r.entry_ref] = r.private_head_in;
					o.chain_head = {1'b0, r.entry_ref};
				end else begin
					o.chain_head = r.private_head_in;
				end
			end
			gtea_pkg::OP_FREE_BATCH: begin
				walk = {1'b0, r.entry_ref};
				for (int i = 0; i < r.batch_count; i++) begin
					if (walk >= ENTRIES)
						break;
					idx = walk;
					walk = link_mem[idx];
					return_entry(idx);
				end
			end
			gtea_pkg::OP_REMOTE: begin
				if (in_range) begin
					flag_mem[r.entry_ref] = r.remote_flags;
					frame_mem[r.entry_ref] = r.frame_number;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		gtea_pkg::rsp_t want;
		gtea_pkg::rsp_t got;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				link_mem[i] = 12'(i + 1);
				flag_mem[i] = '0;
				frame_mem[i] = '0;
			end
			free_head = '0;
			expected_q.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = rsp.data;
				if (expected_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("ERROR: result with nothing expected: %p", got);
				end else begin
					want = expected_q.pop_front();
					if (got.status !== want.status || got.result_ref !== want.result_ref
						|| got.chain_head !== want.chain_head
						|| got.chain_terminal !== want.chain_terminal
						|| got.frame_out !== want.frame_out
						|| got.busy_bits !== want.busy_bits) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("ERROR: result mismatch\n  expected %p\n  actual   %p",
								want, got);
					end
				end
			end
			if (req.valid && req.ready)
				expected_q.push_back(apply_request(req.data));
			outstanding <= expected_q.size();
		end
	end
endmodule

// ----- tb/grant_table_entry_allocator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grant_table_entry_allocator_test
// Drives the grant table allocator with a directed opening (full reserve,
// empty list, every opcode and corner case) and then random request mixes
// aimed at a small window of entries, with random gaps on both channels.
// The scoreboard and the checker bound into the block do all checking.
// ----------------------------------------------------------------------------
module grant_table_entry_allocator_test;
	localparam int unsigned N_ENTRIES = gtea_pkg::ENTRIES_DEF;
	localparam int RANDOM_ITEMS = 430;
	localparam int CYCLE_LIMIT = 5000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   outstanding;
	int   cycle_count = 0;
	int   result_stall = 0;
	bit   result_burst = 1'b0;
	bit   frame_set [N_ENTRIES];

	gtea_req_if req ();
	gtea_rsp_if rsp ();

	grant_table_entry_allocator #(.ENTRIES(N_ENTRIES)) uut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp)
	);

	gtea_scoreboard #(.ENTRIES(N_ENTRIES)) scoreboard (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side back-pressure: a fresh stall length for every transaction.
	always @(posedge clk) begin
		int stall;
		stall = result_stall;
		if (rsp.valid && rsp.ready) begin
			if ($urandom_range(0, 19) == 0)
				result_burst = !result_burst;
			stall = result_burst ? 0 : $urandom_range(0, 10);
		end
		if (stall > 0) begin
			rsp.ready <= 1'b0;
			result_stall <= stall - 1;
		end else begin
			rsp.ready <= 1'b1;
			result_stall <= 0;
		end
	end

	function automatic gtea_pkg::req_t make_req(logic [3:0] op, int ref_idx, int count = 0);
		gtea_pkg::req_t r;
		r = '0;
		r.opcode = op;
		r.entry_ref = 11'(ref_idx);
		r.domain_id = 16'($urandom);
		r.frame_number = $urandom | 32'd1;
		r.read_only = 1'($urandom);
		r.batch_count = 12'(count);
		return r;
	endfunction

	function automatic int pick_ref();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, N_ENTRIES - 1);
		return $urandom_range(0, 47);
	endfunction

	function automatic int pick_count();
		case ($urandom_range(0, 49))
			0: return N_ENTRIES;
			1: return $urandom_range(0, N_ENTRIES);
			default: return $urandom_range(0, 6);
		endcase
	endfunction

	function automatic gtea_pkg::req_t make_random_req();
		gtea_pkg::req_t r;
		int   op;
		op = $urandom_range(0, 99);
		r = make_req(gtea_pkg::OP_GRANT, pick_ref(), pick_count());
		r.private_head_in = 12'($urandom_range(0, 63));
		r.chain_end = 12'($urandom_range(0, 63));
		if ($urandom_range(0, 15) == 0) begin
			r.private_head_in = 12'($urandom_range(0, N_ENTRIES));
			r.chain_end = 12'($urandom_range(0, N_ENTRIES));
		end
		r.remote_flags = $urandom_range(0, 1) ? 16'($urandom)
			: 16'(1 << $urandom_range(0, 4)) | ($urandom_range(0, 1) ? gtea_pkg::F_BUSY : 16'd0);
		if ($urandom_range(0, 3) == 0)
			r.frame_number = '0;
		if (op < 12) r.opcode = gtea_pkg::OP_GRANT;
		else if (op < 20) r.opcode = gtea_pkg::OP_GRANT_REF;
		else if (op < 28) r.opcode = gtea_pkg::OP_XFER;
		else if (op < 34) r.opcode = gtea_pkg::OP_XFER_REF;
		else if (op < 42) r.opcode = gtea_pkg::OP_QUERY;
		else if (op < 52) r.opcode = gtea_pkg::OP_END;
		else if (op < 62) r.opcode = gtea_pkg::OP_END_XFER;
		else if (op < 69) r.opcode = gtea_pkg::OP_RESERVE;
		else if (op < 76) r.opcode = gtea_pkg::OP_CLAIM;
		else if (op < 82) r.opcode = gtea_pkg::OP_RELEASE;
		else if (op < 88) r.opcode = gtea_pkg::OP_FREE_BATCH;
		else if (op < 98) r.opcode = gtea_pkg::OP_REMOTE;
		else r.opcode = 4'(12 + $urandom_range(0, 3));
		// Never end a transfer whose frame was never stored.
		if (r.opcode == gtea_pkg::OP_END_XFER && !frame_set[r.entry_ref])
			r.opcode = gtea_pkg::OP_QUERY;
		return r;
	endfunction

	task automatic send(gtea_pkg::req_t r);
		int gap;
		gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= r;
		if (r.opcode == gtea_pkg::OP_GRANT_REF || r.opcode == gtea_pkg::OP_XFER_REF
			|| r.opcode == gtea_pkg::OP_REMOTE)
			frame_set[r.entry_ref] = 1'b1;
		do
			@(posedge clk);
		while (!req.ready);
	endtask

	initial begin
		gtea_pkg::req_t r;
		req.valid = 1'b0;
		req.data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Take the whole list, then run on an empty list.
		send(make_req(gtea_pkg::OP_RESERVE, 0, N_ENTRIES));
		send(make_req(gtea_pkg::OP_GRANT, 0));
		send(make_req(gtea_pkg::OP_XFER, 0));
		send(make_req(gtea_pkg::OP_RESERVE, 0, 1));
		send(make_req(gtea_pkg::OP_FREE_BATCH, 0, N_ENTRIES));
		send(make_req(gtea_pkg::OP_RESERVE, 0, N_ENTRIES + 1));
		send(make_req(gtea_pkg::OP_GRANT, 0));
		send(make_req(gtea_pkg::OP_XFER, 0));
		send(make_req(gtea_pkg::OP_GRANT_REF, N_ENTRIES - 1));
		send(make_req(gtea_pkg::OP_XFER_REF, 5));
		send(make_req(gtea_pkg::OP_END_XFER, 5));
		r = make_req(gtea_pkg::OP_REMOTE, 6);
		r.remote_flags = gtea_pkg::F_BUSY | gtea_pkg::F_PERMIT;
		send(r);
		send(make_req(gtea_pkg::OP_QUERY, 6));
		send(make_req(gtea_pkg::OP_END, 6));
		r = make_req(gtea_pkg::OP_REMOTE, 7);
		r.remote_flags = 16'hFFFF;
		r.frame_number = 32'hFFFF_FFFF;
		send(r);
		send(make_req(gtea_pkg::OP_END_XFER, 7));
		r = make_req(gtea_pkg::OP_REMOTE, 8);
		r.remote_flags = gtea_pkg::F_XFER | gtea_pkg::F_RDONLY;
		r.frame_number = '0;
		send(r);
		send(make_req(gtea_pkg::OP_END_XFER, 8));
		r = make_req(gtea_pkg::OP_CLAIM, 0);
		r.private_head_in = 12'd3;
		r.chain_end = 12'd3;
		send(r);
		r.private_head_in = 12'(N_ENTRIES);
		r.chain_end = 12'd0;
		send(r);
		r.private_head_in = 12'd5;
		send(r);
		r = make_req(gtea_pkg::OP_RELEASE, 9);
		r.private_head_in = 12'(N_ENTRIES);
		send(r);
		for (int op = 12; op < 16; op++)
			send(make_req(4'(op), 1));

		for (int i = 0; i < RANDOM_ITEMS; i++)
			send(make_random_req());
		req.valid <= 1'b0;

		// The outstanding count is registered, so it settles only after the last transaction is taken.
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
